// ----- rtl/qat_pkg.sv -----
// Shared types, constants and widths of the quoted argument tokenizer.
package qat_pkg;

  localparam int QAT_MAX_TOKEN_LEN = 256;
  localparam int QAT_MAX_TOKENS    = 1024;
  localparam int QAT_MAX_RES       = 4;
  localparam int QAT_QDEPTH        = 4;

  localparam int QAT_LEN_W  = $clog2(QAT_MAX_TOKEN_LEN + 1);
  localparam int QAT_CNT_W  = $clog2(QAT_MAX_TOKENS + 1);
  localparam int QAT_N_W    = $clog2(QAT_MAX_RES + 1);
  localparam int QAT_RES_IW = $clog2(QAT_MAX_RES);
  localparam int QAT_QP_W   = $clog2(QAT_QDEPTH);
  localparam int QAT_QC_W   = $clog2(QAT_QDEPTH + 1);

  localparam logic [QAT_LEN_W-1:0] QAT_LEN_LIMIT = QAT_LEN_W'(QAT_MAX_TOKEN_LEN);
  localparam logic [QAT_CNT_W-1:0] QAT_CNT_LIMIT = QAT_CNT_W'(QAT_MAX_TOKENS);
  localparam logic [15:0]          QAT_LINE_MAX  = 16'hFFFF;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_BSL  = 8'h5C;

  typedef enum logic [2:0] {
    K_CHAR    = 3'd0,
    K_TOKEND  = 3'd1,
    K_CMDEND  = 3'd2,
    K_INEND   = 3'd3,
    K_OPENQ   = 3'd4,
    K_TOOLONG = 3'd5,
    K_TOOMANY = 3'd6
  } qat_kind_t;

  typedef struct packed {
    logic                 bs;
    logic                 cmt;
    logic                 dq;
    logic                 sq;
    logic [QAT_LEN_W-1:0] len;
    logic [QAT_CNT_W-1:0] cnt;
    logic [15:0]          line;
    logic                 halted;
  } qat_state_t;

  typedef struct packed {
    logic [QAT_N_W-1:0]                n;
    qat_kind_t [QAT_MAX_RES-1:0]       kind;
    logic [QAT_MAX_RES-1:0][7:0]       chr;
    logic [15:0]                       line;
  } qat_bundle_t;

  typedef struct packed {
    qat_state_t  s;
    qat_bundle_t b;
  } qat_work_t;

endpackage

// ----- rtl/qat_front.sv -----
// Front end: accepts bytes, tracks lexer state and builds the result bundle of each byte.
module qat_front import qat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        q_full,
  output logic        q_push,
  output qat_bundle_t q_data
);

  qat_state_t state_r;
  qat_state_t state_nxt;
  qat_work_t  work;
  logic       acc;

  function automatic qat_bundle_t push(qat_bundle_t b, qat_kind_t k, logic [7:0] ch);
    qat_bundle_t r;
    r = b;
    if (r.n < QAT_N_W'(QAT_MAX_RES)) begin
      r.kind[r.n[QAT_RES_IW-1:0]] = k;
      r.chr[r.n[QAT_RES_IW-1:0]]  = (k == K_CHAR) ? ch : 8'h00;
      r.n = r.n + QAT_N_W'(1);
    end
    return r;
  endfunction

  function automatic qat_work_t fail(qat_work_t w, qat_kind_t k);
    qat_work_t r;
    r = w;
    r.b = push(r.b, k, 8'h00);
    r.s.halted = 1'b1;
    return r;
  endfunction

  function automatic qat_work_t append(qat_work_t w, logic [7:0] ch);
    qat_work_t r;
    r = w;
    if (!r.s.halted) begin
      if (r.s.len >= QAT_LEN_LIMIT) begin
        r = fail(r, K_TOOLONG);
      end else begin
        r.b = push(r.b, K_CHAR, ch);
        r.s.len = r.s.len + QAT_LEN_W'(1);
      end
    end
    return r;
  endfunction

  function automatic qat_work_t end_token(qat_work_t w);
    qat_work_t r;
    r = w;
    if (!r.s.halted) begin
      if (r.s.bs) begin
        r.s.bs = 1'b0;
        r = append(r, CH_BSL);
      end
      if (!r.s.halted && (r.s.len != '0)) begin
        if (r.s.cnt >= QAT_CNT_LIMIT) begin
          r = fail(r, K_TOOMANY);
        end else begin
          r.b = push(r.b, K_TOKEND, 8'h00);
          r.s.cnt = r.s.cnt + QAT_CNT_W'(1);
          r.s.len = '0;
        end
      end
    end
    return r;
  endfunction

  function automatic qat_work_t end_command(qat_work_t w);
    qat_work_t r;
    r = end_token(w);
    if (!r.s.halted) begin
      if (r.s.cnt != '0) begin
        r.b = push(r.b, K_CMDEND, 8'h00);
      end
      r.s.cnt = '0;
    end
    return r;
  endfunction

  function automatic qat_work_t step(qat_state_t st, logic [7:0] ch, logic eof);
    qat_work_t w;
    logic      take;
    w.s  = st;
    w.b  = '0;
    take = 1'b0;
    if (eof) begin
      if (!w.s.halted) begin
        if (w.s.dq || w.s.sq) begin
          w = fail(w, K_OPENQ);
        end else begin
          w = end_command(w);
        end
      end
      w.b = push(w.b, K_INEND, 8'h00);
      w.b.line = w.s.line;
      w.s = '0;
    end else begin
      if (!w.s.halted) begin
        if ((ch == CH_NL) || (ch == CH_CR)) begin
          w.s.cmt = 1'b0;
          if (!w.s.bs && (w.s.dq || w.s.sq)) begin
            w = fail(w, K_OPENQ);
          end else begin
            if (w.s.line != QAT_LINE_MAX) begin
              w.s.line = w.s.line + 16'd1;
            end
            if (w.s.bs) begin
              w.s.bs = 1'b0;
            end else begin
              w = end_command(w);
            end
          end
        end else if (!w.s.cmt) begin
          take = 1'b1;
          if (!w.s.bs) begin
            if (!w.s.dq && !w.s.sq) begin
              if (ch == CH_SEMI) begin
                w = end_command(w);
                take = 1'b0;
              end else if (ch == CH_HASH) begin
                w.s.cmt = 1'b1;
                take = 1'b0;
              end else if ((ch == CH_SP) || (ch == CH_TAB)) begin
                w = end_token(w);
                take = 1'b0;
              end else if (ch == CH_BSL) begin
                w.s.bs = 1'b1;
                take = 1'b0;
              end
            end
            if (take && !w.s.sq && (ch == CH_DQ)) begin
              w.s.dq = ~w.s.dq;
              take = 1'b0;
            end
            if (take && !w.s.dq && (ch == CH_SQ)) begin
              w.s.sq = ~w.s.sq;
              take = 1'b0;
            end
          end else begin
            w.s.bs = 1'b0;
            w = append(w, CH_BSL);
          end
          if (take) begin
            w = append(w, ch);
          end
        end
      end
      w.b.line = w.s.line;
    end
    return w;
  endfunction

  assign in_tready = ~q_full;
  assign acc       = in_tvalid & in_tready;

  always_comb begin
    work      = step(state_r, in_tdata, in_tlast);
    state_nxt = acc ? work.s : state_r;
  end

  assign q_push = acc & (work.b.n != '0);
  assign q_data = work.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_bs_outside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bs |-> (!state_r.dq && !state_r.sq && !state_r.cmt))
    else $error("pending backslash inside a quote or comment");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && state_r.halted && !in_tlast) |-> !q_push)
    else $error("halted lexer produced a result for a byte");

endmodule

// ----- rtl/qat_queue.sv -----
// Short bundle queue between the front end and the result sequencer.
module qat_queue import qat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  qat_bundle_t push_data,
  output logic        full,
  input  logic        pop,
  output qat_bundle_t pop_data,
  output logic        nonempty
);

  qat_bundle_t           mem_r [QAT_QDEPTH];
  logic [QAT_QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAT_QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAT_QC_W-1:0]   count_r, count_nxt;

  localparam logic [QAT_QP_W-1:0] PTR_LAST = QAT_QP_W'(QAT_QDEPTH - 1);
  localparam logic [QAT_QC_W-1:0] CNT_FULL = QAT_QC_W'(QAT_QDEPTH);

  assign full     = (count_r == CNT_FULL);
  assign nonempty = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + QAT_QP_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + QAT_QP_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QAT_QC_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QAT_QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("bundle queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("bundle queue read while empty");

endmodule

// ----- rtl/qat_back.sv -----
// Result sequencer: hands out the results of each queued bundle one beat at a time.
module qat_back import qat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  qat_bundle_t q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  qat_bundle_t           cur_r;
  logic                  cur_vld_r, cur_vld_nxt;
  logic [QAT_RES_IW-1:0] idx_r, idx_nxt;
  logic [QAT_N_W-1:0]    n_m1;
  logic                  fire;
  logic                  done;

  assign n_m1       = cur_r.n - QAT_N_W'(1);
  assign out_tvalid = cur_vld_r;
  assign out_tlast  = (QAT_N_W'(idx_r) == n_m1);
  assign out_tuser  = cur_r.kind[idx_r];
  assign out_tdata  = {cur_r.line, cur_r.chr[idx_r]};

  assign fire  = out_tvalid & out_tready;
  assign done  = fire & out_tlast;
  assign q_pop = q_nonempty & (~cur_vld_r | done);

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    idx_nxt     = idx_r;
    if (q_pop) begin
      cur_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (done) begin
      cur_vld_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + QAT_RES_IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (QAT_N_W'(idx_r) < cur_r.n))
    else $error("result index beyond the bundle size");

endmodule

// ----- rtl/quoted_argument_tokenizer_unit.sv -----
// Top level of the quoted argument tokenizer: front end, bundle queue and result sequencer.
// Results of a byte pass through the bundle queue and the sequencer's current bundle.
// Throughput: one byte per cycle while the four-entry bundle queue has room; results leave
// at one beat per cycle while out_tready is high, one beat for each result of a byte.
// Reset (synchronous, active low) clears the lexer state, empties the queue and drops
// any result in flight; no clearing pass follows.
module quoted_argument_tokenizer_unit import qat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] char_value, [23:8] line_number
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last
);

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_nonempty;
  qat_bundle_t q_wdata;
  qat_bundle_t q_rdata;

  qat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  qat_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .nonempty  (q_nonempty)
  );

  qat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- test/quoted_argument_tokenizer_unit_test.sv -----
// Self-checking stream testbench of the quoted argument tokenizer against a local predictor.
module quoted_argument_tokenizer_unit_test;
  import qat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    qat_kind_t   kind;
    logic [7:0]  cv;
    logic [15:0] line;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic        eof;
    logic [7:0]  ch;
    logic        typed;
    qat_kind_t   kind;
    logic [7:0]  cv;
    logic [15:0] line;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{1'b0, 8'h61,   1'b1, K_CHAR,   8'h61, 16'd0},
    '{1'b0, 8'hFF,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, 8'h00,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_SP,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_BSL,  1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, 8'h78,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_BSL,  1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_NL,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_TAB,  1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_HASH, 1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, 8'h7A,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_CR,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_SQ,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_SP,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_DQ,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_SQ,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_BSL,  1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b1, 8'h00,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_DQ,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_NL,   1'b1, K_OPENQ,  8'h00, 16'd0},
    '{1'b0, 8'h62,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b1, 8'hA5,   1'b1, K_INEND,  8'h00, 16'd0},
    '{1'b0, CH_SQ,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b1, 8'h00,   1'b0, K_CHAR,   8'h00, 16'd0},
    '{1'b0, CH_SEMI, 1'b0, K_CHAR,   8'h00, 16'd0}
  };

  localparam int SEND_IDLE_PCT [4] = '{0, 51, 0, 20};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 51, 20};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  beat_t awaited_beats [$];
  beat_t step_beats [$];

  logic                 esc_pend = 1'b0;
  logic                 cmt_on = 1'b0;
  logic                 dq_on = 1'b0;
  logic                 sq_on = 1'b0;
  logic [QAT_LEN_W-1:0] tok_len = '0;
  logic [QAT_CNT_W-1:0] tok_cnt = '0;
  logic [15:0]          line_cnt = '0;
  logic                 stopped = 1'b0;

  quoted_argument_tokenizer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_state();
    esc_pend = 1'b0;
    cmt_on   = 1'b0;
    dq_on    = 1'b0;
    sq_on    = 1'b0;
    tok_len  = '0;
    tok_cnt  = '0;
    line_cnt = '0;
    stopped  = 1'b0;
  endfunction

  function automatic void emit_beat(qat_kind_t kind, logic [7:0] ch);
    beat_t b;
    if (step_beats.size() < QAT_MAX_RES) begin
      b.kind = kind;
      b.cv   = (kind == K_CHAR) ? ch : 8'h00;
      b.line = line_cnt;
      b.last = 1'b0;
      step_beats.push_back(b);
    end
  endfunction

  function automatic void raise_error(qat_kind_t kind);
    emit_beat(kind, 8'h00);
    stopped = 1'b1;
  endfunction

  function automatic void add_char(logic [7:0] ch);
    if (stopped) return;
    if (tok_len >= QAT_LEN_LIMIT) begin
      raise_error(K_TOOLONG);
      return;
    end
    emit_beat(K_CHAR, ch);
    tok_len++;
  endfunction

  function automatic void close_token();
    if (stopped) return;
    if (esc_pend) begin
      esc_pend = 1'b0;
      add_char(CH_BSL);
      if (stopped) return;
    end
    if (tok_len != 0) begin
      if (tok_cnt >= QAT_CNT_LIMIT) begin
        raise_error(K_TOOMANY);
        return;
      end
      emit_beat(K_TOKEND, 8'h00);
      tok_cnt++;
      tok_len = '0;
    end
  endfunction

  function automatic void close_command();
    close_token();
    if (stopped) return;
    if (tok_cnt != 0) emit_beat(K_CMDEND, 8'h00);
    tok_cnt = '0;
  endfunction

  function automatic void tokenize_byte(logic [7:0] ch, logic eof);
    logic  take;
    beat_t b;
    step_beats.delete();
    take = 1'b1;
    if (eof) begin
      if (!stopped) begin
        if (dq_on || sq_on) raise_error(K_OPENQ);
        else close_command();
      end
      emit_beat(K_INEND, 8'h00);
      clear_state();
    end else if (!stopped) begin
      if (ch == CH_NL || ch == CH_CR) begin
        cmt_on = 1'b0;
        if (!esc_pend && (dq_on || sq_on)) begin
          raise_error(K_OPENQ);
        end else begin
          if (line_cnt != QAT_LINE_MAX) line_cnt++;
          if (esc_pend) esc_pend = 1'b0;
          else close_command();
        end
      end else if (!cmt_on) begin
        if (!esc_pend) begin
          if (!dq_on && !sq_on) begin
            case (ch)
              CH_SEMI: begin
                close_command();
                take = 1'b0;
              end
              CH_HASH: begin
                cmt_on = 1'b1;
                take = 1'b0;
              end
              CH_SP, CH_TAB: begin
                close_token();
                take = 1'b0;
              end
              CH_BSL: begin
                esc_pend = 1'b1;
                take = 1'b0;
              end
              default: ;
            endcase
          end
          if (take && !sq_on && ch == CH_DQ) begin
            dq_on = !dq_on;
            take = 1'b0;
          end
          if (take && !dq_on && ch == CH_SQ) begin
            sq_on = !sq_on;
            take = 1'b0;
          end
        end else begin
          esc_pend = 1'b0;
          add_char(CH_BSL);
        end
        if (take) add_char(ch);
      end
    end
    if (step_beats.size() != 0) begin
      b = step_beats.pop_back();
      b.last = 1'b1;
      step_beats.push_back(b);
    end
  endfunction

  function automatic stim_row_t plain(logic eof, logic [7:0] ch);
    stim_row_t r;
    r = '{eof, ch, 1'b0, K_CHAR, 8'h00, 16'd0};
    return r;
  endfunction

  function automatic stim_row_t random_row();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return plain(1'b1, 8'($urandom_range(255)));
    if (pick < 45) return plain(1'b0, 8'($urandom_range(122, 97)));
    if (pick < 55) return plain(1'b0, $urandom_range(1) ? CH_SP : CH_TAB);
    if (pick < 60) return plain(1'b0, CH_SEMI);
    if (pick < 66) return plain(1'b0, $urandom_range(1) ? CH_NL : CH_CR);
    if (pick < 69) return plain(1'b0, CH_HASH);
    if (pick < 75) return plain(1'b0, $urandom_range(1) ? CH_DQ : CH_SQ);
    if (pick < 80) return plain(1'b0, CH_BSL);
    return plain(1'b0, 8'($urandom_range(255)));
  endfunction

  task automatic send_row(stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r.ch;
    in_tlast  <= r.eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokenize_byte(r.ch, r.eof);
    if (r.typed) awaited_beats.push_back('{r.kind, r.cv, r.line, 1'b1});
    else foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_beats.size() == 0) begin
        $error("kind: expected no beat, got %0d", out_tuser);
        mismatch_count++;
      end else begin
        want = awaited_beats.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[7:0] !== want.cv) begin
          $error("char_value: expected %0d, got %0d", want.cv, out_tdata[7:0]);
          mismatch_count++;
        end
        if (out_tdata[23:8] !== want.line) begin
          $error("line_number: expected %0d, got %0d", want.line, out_tdata[23:8]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int fed;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i]) send_row(DIRECTED_ROWS[i]);

    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      fed = 0;
      while (fed < 75) begin
        fed++;
        send_row(random_row());
      end
      drain_results();
    end

    in_tvalid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
